### design/generational_handle_allocator_top_macros.svh
// Assertion helpers shared by the allocator RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define GHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gha_pkg.sv
`timescale 1ns / 1ps

package gha_pkg;

  localparam int DEF_SLOTS    = 1024;
  localparam int DEF_GEN_BITS = 16;

  // Fixed widths of the handle fields on the ports.
  localparam int IDX_BITS = 10;
  localparam int GEN_OUT_BITS = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_STALE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     opcode;
    logic [IDX_BITS-1:0]     slot_index;
    logic [GEN_OUT_BITS-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]     result_index;
    logic [GEN_OUT_BITS-1:0] result_generation;
    logic                    handle_live;
    status_e                 status;
  } rsp_t;

endpackage

### design/gha_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module gha_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 17,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/generational_handle_allocator_top.sv
`timescale 1ns / 1ps

`include "generational_handle_allocator_top_macros.svh"

// Generational handle allocator.
// Command channel: a request beat (req_i) is taken at a rising edge with start high
// and busy low. Opcodes: allocate, deallocate a handle, check a handle.
// Result channel: done_o is high for exactly one cycle with rsp_o valid; the
// receiver must take the beat in that cycle, there is no back-pressure.
// Timing: busy stays high while a request is worked in S_LOOK (and then in S_POP for an
// allocate that reuses a freed slot), and the result shows in the first cycle with
// busy low, so a new request can be taken at the edge that ends that cycle.
// An allocate that pops the free stack therefore passes S_LOOK and then S_POP.
// The extra state is set by the registered read data of the slot table and free stack
// memories: a pop reads the stack, then reads the table entry it names.
// Reset clears the free count and the used-slot count; the memories are not
// cleared, since no entry is used before it has been written.
module generational_handle_allocator_top
  import gha_pkg::*;
#(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int GEN_BITS = DEF_GEN_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int ENT_W  = GEN_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_POP
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  rsp_t             rsp_q, rsp_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
  logic [IDX_W-1:0] pop_slot_q, pop_slot_d;

  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [ENT_W-1:0] tbl_wdata, tbl_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;
  logic [IDX_W-1:0] stk_wdata, stk_rdata;

  logic [IDX_W+IDX_BITS-1:0]     in_idx_ext, q_idx_ext;
  logic [IDX_W-1:0]              in_idx, q_idx;
  logic                          in_range, gen_match, handle_ok;
  logic [GEN_BITS-1:0]           tbl_gen, new_gen;
  logic [GEN_BITS+GEN_OUT_BITS-1:0] new_gen_ext;
  logic [IDX_W-1:0]              alloc_slot;
  logic [IDX_W+IDX_BITS-1:0]     alloc_slot_ext;
  logic [CNT_W-1:0]              free_dec;

  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_slot_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH (IDX_W),
    .AW    (IDX_W)
  ) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign in_idx_ext = {{IDX_W{1'b0}}, req_i.slot_index};
  assign q_idx_ext  = {{IDX_W{1'b0}}, req_q.slot_index};
  assign in_idx     = in_idx_ext[IDX_W-1:0];
  assign q_idx      = q_idx_ext[IDX_W-1:0];

  assign tbl_gen = tbl_rdata[GEN_BITS-1:0];
  assign new_gen = tbl_gen + {{(GEN_BITS-1){1'b0}}, 1'b1};
  assign new_gen_ext = {{GEN_OUT_BITS{1'b0}}, new_gen};

  // The full handle index is compared, so an index that aliases after
  // truncation to the table width still counts as out of range.
  assign in_range  = {{CNT_W{1'b0}}, req_q.slot_index} < {{IDX_BITS{1'b0}}, used_q};
  assign gen_match = {{GEN_BITS{1'b0}}, req_q.handle_generation}
                     == {{GEN_OUT_BITS{1'b0}}, tbl_gen};
  assign handle_ok = in_range && gen_match && tbl_rdata[GEN_BITS];

  assign alloc_slot     = (state_q == S_POP) ? pop_slot_q : used_q[IDX_W-1:0];
  assign alloc_slot_ext = {{IDX_BITS{1'b0}}, alloc_slot};
  assign free_dec       = free_cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    rsp_d      = '0;
    done_d     = 1'b0;
    used_d     = used_q;
    free_cnt_d = free_cnt_q;
    pop_slot_d = pop_slot_q;
    tbl_we     = 1'b0;
    tbl_waddr  = q_idx;
    tbl_wdata  = {1'b0, tbl_gen};
    tbl_raddr  = in_idx;
    stk_we     = 1'b0;
    stk_waddr  = free_cnt_q[IDX_W-1:0];
    stk_wdata  = q_idx;
    stk_raddr  = free_dec[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (req_q.opcode)
          OP_ALLOC: begin
            if (free_cnt_q != '0) begin
              // Reuse the most recently freed slot; its entry is read next.
              free_cnt_d = free_dec;
              pop_slot_d = stk_rdata;
              tbl_raddr  = stk_rdata;
              state_d    = S_POP;
              done_d     = 1'b0;
            end else if (used_q < CNT_W'(SLOTS)) begin
              tbl_we    = 1'b1;
              tbl_waddr = used_q[IDX_W-1:0];
              tbl_wdata = {1'b1, {GEN_BITS{1'b0}}};
              used_d    = used_q + {{(CNT_W-1){1'b0}}, 1'b1};
              rsp_d.result_index = alloc_slot_ext[IDX_BITS-1:0];
            end else begin
              rsp_d.status = STAT_FULL;
            end
          end
          OP_FREE: begin
            if (handle_ok && (free_cnt_q < CNT_W'(SLOTS))) begin
              tbl_we     = 1'b1;
              tbl_wdata  = {1'b0, tbl_gen};
              stk_we     = 1'b1;
              free_cnt_d = free_cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
            end else begin
              rsp_d.status = STAT_STALE;
            end
          end
          OP_CHECK: begin
            rsp_d.handle_live = handle_ok;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        tbl_we    = 1'b1;
        tbl_waddr = pop_slot_q;
        tbl_wdata = {1'b1, new_gen};
        rsp_d.result_index      = alloc_slot_ext[IDX_BITS-1:0];
        rsp_d.result_generation = new_gen_ext[GEN_OUT_BITS-1:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= '0;
      rsp_q      <= '0;
      done_q     <= 1'b0;
      used_q     <= '0;
      free_cnt_q <= '0;
      pop_slot_q <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      rsp_q      <= rsp_d;
      done_q     <= done_d;
      used_q     <= used_d;
      free_cnt_q <= free_cnt_d;
      pop_slot_q <= pop_slot_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `GHA_ASSERT_NOW(a_free_le_used, 1'b1, free_cnt_q <= used_q, "free count above used slots")
  `GHA_ASSERT_NEXT(a_used_mono, 1'b1, used_q >= $past(used_q), "used slot count went down")
  `GHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "accepted beat not in work")
  `GHA_ASSERT_NOW(a_done_idle, done_o, !busy, "result beat while still busy")

endmodule
